@@ sv/sfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync-length frame receiver package
// Shared widths, codes, reset values and types of the frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int FRAME_BYTES_DEF = 64;
   localparam int FIXED_BYTES     = 11;

   localparam int STATUS_W   = 3;
   localparam int BYTE_W     = 8;
   localparam int IDX_W      = 6;
   localparam int PLEN_W     = 6;
   localparam int TICK_W     = 10;
   localparam int LEN_W      = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [STATUS_W-1:0] ST_TAKEN    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SYNC = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_VER  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FRAME    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 3'd5;

   localparam logic [CSR_IDX_W-1:0] REG_SYNC_WORD   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VERSION     = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_PAYLOAD = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RX_TIMEOUT  = 8'd3;

   localparam logic [15:0]       SYNC_WORD_RST   = 16'hBEBE;
   localparam logic [BYTE_W-1:0] VERSION_RST     = 8'd100;
   localparam logic [PLEN_W-1:0] MAX_PAYLOAD_RST = 6'd39;
   localparam logic [TICK_W-1:0] RX_TIMEOUT_RST  = 10'd100;

   // Byte counts, after the byte is taken, at which the header checks run.
   localparam int CNT_SYNC_HI = 2;
   localparam int CNT_VERSION = 3;
   localparam int CNT_LEN_LO  = 8;
   localparam int CNT_LEN_HI  = 9;

   typedef struct packed {
      logic [15:0]       sync_word;
      logic [BYTE_W-1:0] frame_version;
      logic [PLEN_W-1:0] max_payload;
      logic [TICK_W-1:0] rx_timeout;
   } cfg_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   frame_byte;
      logic [IDX_W-1:0]    byte_index;
      logic                last;
   } res_type;

endpackage

@@ sv/sfr_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Carries received bytes and timer ticks into the frame receiver.
// ----------------------------------------------------------------------------
interface sfr_req_if;
   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic [sfr_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output operation, output rx_byte, input ready);
   modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

@@ sv/sfr_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Carries status results and replayed frame bytes out of the frame receiver.
// ----------------------------------------------------------------------------
interface sfr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sfr_pkg::STATUS_W-1:0] status;
   logic [sfr_pkg::BYTE_W-1:0]   frame_byte;
   logic [sfr_pkg::IDX_W-1:0]    byte_index;
   logic                         last;

   modport source (output valid, output status, output frame_byte, output byte_index,
                   output last, input ready);
   modport sink   (input valid, input status, input frame_byte, input byte_index,
                   input last, output ready);
endinterface

@@ sv/sfr_csr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register write channel
// Carries register index and write data into the frame receiver.
// ----------------------------------------------------------------------------
interface sfr_csr_if;
   logic                           valid;
   logic                           ready;
   logic [sfr_pkg::CSR_IDX_W-1:0]  index;
   logic [sfr_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/sfr_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver registers
// Holds sync word, version, payload limit and timeout, written by index.
// ----------------------------------------------------------------------------
module sfr_csr (
   input  logic             clock,
   input  logic             reset,
   sfr_csr_if.sink          csr_chan,
   output sfr_pkg::cfg_type cfg
);

   sfr_pkg::cfg_type cfg_ff;
   sfr_pkg::cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            sfr_pkg::REG_SYNC_WORD:   cfg_in.sync_word = csr_chan.data;
            sfr_pkg::REG_VERSION:
               cfg_in.frame_version = csr_chan.data[sfr_pkg::BYTE_W-1:0];
            sfr_pkg::REG_MAX_PAYLOAD:
               cfg_in.max_payload = csr_chan.data[sfr_pkg::PLEN_W-1:0];
            sfr_pkg::REG_RX_TIMEOUT:
               cfg_in.rx_timeout = csr_chan.data[sfr_pkg::TICK_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_word     <= sfr_pkg::SYNC_WORD_RST;
         cfg_ff.frame_version <= sfr_pkg::VERSION_RST;
         cfg_ff.max_payload   <= sfr_pkg::MAX_PAYLOAD_RST;
         cfg_ff.rx_timeout    <= sfr_pkg::RX_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ sv/sfr_frame_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame byte memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sfr_frame_mem #(
   parameter int DEPTH = sfr_pkg::FRAME_BYTES_DEF
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [sfr_pkg::BYTE_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [sfr_pkg::BYTE_W-1:0] rd_data
);

   logic [sfr_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [sfr_pkg::BYTE_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

@@ sv/sync_length_frame_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync-length frame receiver
// Collects frame bytes in a memory, checks sync, version and length, times out
// idle frames on ticks and replays a complete frame byte by byte.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  req_chan  in         operation, rx_byte
//  rsp_chan  out        status, frame_byte, byte_index, last
//  csr_chan  in         index, data (register writes)
//
//  A request that does not finish a frame is taken only when idle with the pending
//  register empty; its response goes via the pending register to the output register.
//  A finished frame of length + 11 bytes is replayed byte by byte via the single read port
//  of the frame memory, each byte in a read then a load state. Reset is synchronous and
//  does not clear the frame memory. A stalled response side holds one result in the
//  output register and one pending; requests wait while that one is full or a replay runs.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver #(
   parameter int FRAME_BYTES = sfr_pkg::FRAME_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sfr_req_if.sink    req_chan,
   sfr_rsp_if.source  rsp_chan,
   sfr_csr_if.sink    csr_chan
);

   localparam int AW   = $clog2(FRAME_BYTES);
   localparam int CW   = $clog2(FRAME_BYTES + 1);
   localparam int CMPW = (CW > 8) ? CW : 8;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RD   = 2'd1;
   localparam logic [1:0] S_LD   = 2'd2;

   sfr_pkg::cfg_type cfg;

   logic [1:0]                   state_ff, state_in;
   logic                         recv_ff, recv_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [sfr_pkg::PLEN_W-1:0]   plen_ff, plen_in;
   logic [sfr_pkg::TICK_W-1:0]   elapsed_ff, elapsed_in;
   logic [sfr_pkg::BYTE_W-1:0]   byte0_ff, byte0_in;
   logic [sfr_pkg::BYTE_W-1:0]   byte7_ff, byte7_in;
   logic [AW-1:0]                rp_ff, rp_in;
   sfr_pkg::res_type             pend_ff, pend_in;
   logic                         pend_valid_ff, pend_valid_in;
   sfr_pkg::res_type             out_ff, out_in;
   logic                         out_valid_ff, out_valid_in;

   logic                         req_fire;
   logic                         pend_move;
   logic                         mem_wr_en;
   logic [AW-1:0]                mem_wr_addr;
   logic                         mem_rd_en;
   logic [sfr_pkg::BYTE_W-1:0]   mem_rd_data;

   logic [CW-1:0]                cnt_base;
   logic [CW-1:0]                cnt_new;
   logic [sfr_pkg::PLEN_W-1:0]   plen_base;
   logic [sfr_pkg::LEN_W-1:0]    len;
   logic [sfr_pkg::TICK_W-1:0]   el_new;
   logic [sfr_pkg::STATUS_W-1:0] st;
   logic                         rp_last;

   sfr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   sfr_frame_mem #(
      .DEPTH (FRAME_BYTES)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req_chan.rx_byte),
      .rd_en   (mem_rd_en),
      .rd_addr (rp_ff),
      .rd_data (mem_rd_data)
   );

   assign req_chan.ready      = (state_ff == S_IDLE) && !pend_valid_ff;
   assign req_fire            = req_chan.valid && req_chan.ready;
   assign pend_move           = pend_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.status     = out_ff.status;
   assign rsp_chan.frame_byte = out_ff.frame_byte;
   assign rsp_chan.byte_index = out_ff.byte_index;
   assign rsp_chan.last       = out_ff.last;
   assign rp_last             = ((CW'(rp_ff) + 1'b1) == count_ff);

   always_comb begin
      state_in      = state_ff;
      recv_in       = recv_ff;
      count_in      = count_ff;
      plen_in       = plen_ff;
      elapsed_in    = elapsed_ff;
      byte0_in      = byte0_ff;
      byte7_in      = byte7_ff;
      rp_in         = rp_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff && !pend_move;
      out_in        = pend_move ? pend_ff : out_ff;
      out_valid_in  = pend_move || (out_valid_ff && !rsp_chan.ready);
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      cnt_base      = recv_ff ? count_ff : '0;
      cnt_new       = cnt_base + 1'b1;
      plen_base     = recv_ff ? plen_ff : '0;
      mem_wr_addr   = cnt_base[AW-1:0];
      len           = {req_chan.rx_byte, byte7_ff};
      el_new        = elapsed_ff + 1'b1;
      st            = sfr_pkg::ST_TAKEN;

      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_chan.operation == sfr_pkg::OP_TICK)) begin
               if (recv_ff) begin
                  elapsed_in = el_new;
                  if (el_new >= cfg.rx_timeout) begin
                     st       = sfr_pkg::ST_TIMEOUT;
                     recv_in  = 1'b0;
                     count_in = '0;
                  end
               end
               pend_in       = '{st, '0, sfr_pkg::IDX_W'(count_ff), 1'b1};
               pend_valid_in = 1'b1;
            end else if (req_fire) begin
               if (!recv_ff) begin
                  elapsed_in = '0;
               end
               recv_in   = 1'b1;
               mem_wr_en = 1'b1;
               count_in  = cnt_new;
               plen_in   = plen_base;
               if (cnt_base == '0) begin
                  byte0_in = req_chan.rx_byte;
               end
               if (cnt_new == CW'(sfr_pkg::CNT_LEN_LO)) begin
                  byte7_in = req_chan.rx_byte;
               end
               if (cnt_new == CW'(sfr_pkg::CNT_SYNC_HI)) begin
                  if ((byte0_ff != cfg.sync_word[7:0])
                      || (req_chan.rx_byte != cfg.sync_word[15:8])) begin
                     st = sfr_pkg::ST_BAD_SYNC;
                  end
               end else if (cnt_new == CW'(sfr_pkg::CNT_VERSION)) begin
                  if (req_chan.rx_byte != cfg.frame_version) begin
                     st = sfr_pkg::ST_BAD_VER;
                  end
               end else if (cnt_new == CW'(sfr_pkg::CNT_LEN_HI)) begin
                  if ((len > sfr_pkg::LEN_W'(cfg.max_payload))
                      || (len > sfr_pkg::LEN_W'(FRAME_BYTES - sfr_pkg::FIXED_BYTES))) begin
                     st = sfr_pkg::ST_BAD_LEN;
                  end else begin
                     plen_in = len[sfr_pkg::PLEN_W-1:0];
                  end
               end
               if (st != sfr_pkg::ST_TAKEN) begin
                  recv_in       = 1'b0;
                  count_in      = '0;
                  pend_in       = '{st, '0, sfr_pkg::IDX_W'(cnt_new), 1'b1};
                  pend_valid_in = 1'b1;
               end else if ((cnt_new >= CW'(sfr_pkg::CNT_LEN_HI))
                  && (CMPW'(cnt_new)
                      >= (CMPW'(plen_base) + CMPW'(sfr_pkg::FIXED_BYTES)))) begin
                  rp_in    = '0;
                  state_in = S_RD;
               end else begin
                  pend_in       = '{st, '0, sfr_pkg::IDX_W'(cnt_new), 1'b1};
                  pend_valid_in = 1'b1;
               end
            end
         end
         S_RD: begin
            if (!pend_valid_ff || pend_move) begin
               mem_rd_en = 1'b1;
               state_in  = S_LD;
            end
         end
         S_LD: begin
            pend_in       = '{sfr_pkg::ST_FRAME, mem_rd_data,
                              sfr_pkg::IDX_W'(rp_ff), rp_last};
            pend_valid_in = 1'b1;
            if (rp_last) begin
               recv_in  = 1'b0;
               count_in = '0;
               state_in = S_IDLE;
            end else begin
               rp_in    = rp_ff + 1'b1;
               state_in = S_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         recv_ff       <= 1'b0;
         count_ff      <= '0;
         plen_ff       <= '0;
         elapsed_ff    <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         recv_ff       <= recv_in;
         count_ff      <= count_in;
         plen_ff       <= plen_in;
         elapsed_ff    <= elapsed_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte0_ff <= byte0_in;
      byte7_ff <= byte7_in;
      rp_ff    <= rp_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
   end

`ifndef SYNTH
   a_open_count_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) && recv_ff |-> (CMPW'(count_ff) < CMPW'(FRAME_BYTES)))
      else $error("open frame holds a full store while idle");

   a_closed_count_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) && !recv_ff |-> (count_ff == '0))
      else $error("closed frame keeps a byte count");

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LD) |-> !pend_valid_ff)
      else $error("replay load finds the pending register full");

   a_byte_only_on_frame: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_ff.status != sfr_pkg::ST_FRAME) |-> (out_ff.frame_byte == '0))
      else $error("non-frame response carries a byte");
`endif

endmodule

@@ test/sync_length_frame_receiver_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync-length frame receiver testbench
// Sends well-formed, broken and truncated frames mixed with timer ticks in
// random bursts. It reprograms the registers between phases and checks every
// response, field by field, against a predictor of the receiver.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver_tb;

   typedef enum int {
      FR_GOOD,
      FR_BAD_SYNC,
      FR_BAD_VER,
      FR_BAD_LEN,
      FR_CUT,
      FR_NOISE,
      FR_TICKS
   } frame_kind_type;

   class frame_scoreboard_type;
      sfr_pkg::cfg_type           cfg;
      logic [sfr_pkg::BYTE_W-1:0] store [sfr_pkg::FRAME_BYTES_DEF];
      int unsigned                count;
      int unsigned                plen;
      bit                         in_frame;
      logic [sfr_pkg::TICK_W-1:0] ticks;
      sfr_pkg::res_type           pending [$];
      int                         errors;

      function new();
         cfg = '{sfr_pkg::SYNC_WORD_RST, sfr_pkg::VERSION_RST, sfr_pkg::MAX_PAYLOAD_RST,
                 sfr_pkg::RX_TIMEOUT_RST};
         count = 0;
         plen = 0;
         in_frame = 1'b0;
         ticks = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [sfr_pkg::CSR_IDX_W-1:0] idx,
                              logic [sfr_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            sfr_pkg::REG_SYNC_WORD:   cfg.sync_word = data;
            sfr_pkg::REG_VERSION:     cfg.frame_version = data[sfr_pkg::BYTE_W-1:0];
            sfr_pkg::REG_MAX_PAYLOAD: cfg.max_payload = data[sfr_pkg::PLEN_W-1:0];
            sfr_pkg::REG_RX_TIMEOUT:  cfg.rx_timeout = data[sfr_pkg::TICK_W-1:0];
            default: ;
         endcase
      endfunction

      function void push(logic [sfr_pkg::STATUS_W-1:0] st, logic [sfr_pkg::BYTE_W-1:0] b,
                         int unsigned idx, bit fin);
         sfr_pkg::res_type r;
         r.status = st;
         r.frame_byte = b;
         r.byte_index = sfr_pkg::IDX_W'(idx);
         r.last = fin;
         pending.push_back(r);
      endfunction

      function void leave_frame();
         in_frame = 1'b0;
         count = 0;
      endfunction

      function void note_request(logic op, logic [sfr_pkg::BYTE_W-1:0] b);
         int unsigned len;
         int unsigned n;
         if (op == sfr_pkg::OP_TICK) begin
            if (in_frame) begin
               ticks = ticks + 1'b1;
               if (ticks >= cfg.rx_timeout) begin
                  push(sfr_pkg::ST_TIMEOUT, '0, count, 1'b1);
                  leave_frame();
                  return;
               end
            end
            push(sfr_pkg::ST_TAKEN, '0, count, 1'b1);
            return;
         end
         if (!in_frame) begin
            in_frame = 1'b1;
            ticks = '0;
            count = 0;
            plen = 0;
         end
         if (count < sfr_pkg::FRAME_BYTES_DEF) store[count] = b;
         count++;
         if (count == sfr_pkg::CNT_SYNC_HI) begin
            if ({store[1], store[0]} != cfg.sync_word) begin
               push(sfr_pkg::ST_BAD_SYNC, '0, count, 1'b1);
               leave_frame();
               return;
            end
         end else if (count == sfr_pkg::CNT_VERSION) begin
            if (store[sfr_pkg::CNT_VERSION-1] != cfg.frame_version) begin
               push(sfr_pkg::ST_BAD_VER, '0, count, 1'b1);
               leave_frame();
               return;
            end
         end else if (count == sfr_pkg::CNT_LEN_HI) begin
            len = {store[sfr_pkg::CNT_LEN_HI-1], store[sfr_pkg::CNT_LEN_LO-1]};
            if (len > cfg.max_payload
                || len > sfr_pkg::FRAME_BYTES_DEF - sfr_pkg::FIXED_BYTES) begin
               push(sfr_pkg::ST_BAD_LEN, '0, count, 1'b1);
               leave_frame();
               return;
            end
            plen = len;
         end
         if (count >= sfr_pkg::CNT_LEN_HI && count >= plen + sfr_pkg::FIXED_BYTES) begin
            n = (count > sfr_pkg::FRAME_BYTES_DEF) ? sfr_pkg::FRAME_BYTES_DEF : count;
            for (int unsigned i = 0; i < n; i++)
               push(sfr_pkg::ST_FRAME, store[i], i, i + 1 == n);
            leave_frame();
            return;
         end
         push(sfr_pkg::ST_TAKEN, '0, count, 1'b1);
      endfunction

      function void check_result(sfr_pkg::res_type got);
         sfr_pkg::res_type want;
         if (pending.size() == 0) begin
            $error("unexpected response: status %0d frame_byte %0d byte_index %0d last %0d",
                   got.status, got.frame_byte, got.byte_index, got.last);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.frame_byte !== want.frame_byte) begin
            $error("frame_byte: expected %0d, got %0d", want.frame_byte, got.frame_byte);
            errors++;
         end
         if (got.byte_index !== want.byte_index) begin
            $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   sfr_req_if                  req_bus ();
   sfr_rsp_if                  rsp_bus ();
   sfr_csr_if                  csr_bus ();
   frame_scoreboard_type       sb;
   logic [sfr_pkg::BYTE_W-1:0] frame_q [$];
   int                         items_sent = 0;
   int                         burst_left = 0;
   int                         ready_mode = 0;
   int                         ready_hold = 0;

   sync_length_frame_receiver u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         sb.note_request(req_bus.operation, req_bus.rx_byte);
      end
      if (!reset && csr_bus.valid && csr_bus.ready) begin
         sb.write_reg(csr_bus.index, csr_bus.data);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_result({rsp_bus.status, rsp_bus.frame_byte, rsp_bus.byte_index,
                          rsp_bus.last});
      end
   end

   // The response side switches between free flow, light, heavy and near-total stalls.
   always @(posedge clock) begin
      if (ready_hold == 0) begin
         ready_mode <= $urandom_range(0, 3);
         ready_hold <= $urandom_range(10, 60);
      end else begin
         ready_hold <= ready_hold - 1;
      end
      case (ready_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= 1'($urandom_range(0, 1));
         2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_bus.ready <= ($urandom_range(0, 11) == 0);
      endcase
   end

   task automatic send_req(logic op, logic [sfr_pkg::BYTE_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic drain(int settle);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Writes all four registers plus one write to an unused index.
   task automatic program_regs(logic [sfr_pkg::CSR_DATA_W-1:0] sync_data,
                               logic [sfr_pkg::CSR_DATA_W-1:0] ver_data,
                               logic [sfr_pkg::CSR_DATA_W-1:0] max_data,
                               logic [sfr_pkg::CSR_DATA_W-1:0] tmo_data);
      logic [sfr_pkg::CSR_IDX_W-1:0]  idx [5];
      logic [sfr_pkg::CSR_DATA_W-1:0] val [5];
      idx = '{sfr_pkg::REG_SYNC_WORD, sfr_pkg::REG_VERSION, sfr_pkg::REG_MAX_PAYLOAD,
              sfr_pkg::REG_RX_TIMEOUT,
              sfr_pkg::CSR_IDX_W'($urandom_range(sfr_pkg::REG_RX_TIMEOUT + 1, 255))};
      val = '{sync_data, ver_data, max_data, tmo_data, sfr_pkg::CSR_DATA_W'($urandom)};
      for (int i = 0; i < 5; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= idx[i];
         csr_bus.data <= val[i];
         do @(posedge clock); while (!csr_bus.ready);
      end
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void build_frame(int unsigned len_field, int unsigned payload);
      frame_q.delete();
      frame_q.push_back(sb.cfg.sync_word[7:0]);
      frame_q.push_back(sb.cfg.sync_word[15:8]);
      frame_q.push_back(sb.cfg.frame_version);
      repeat (4) frame_q.push_back(sfr_pkg::BYTE_W'($urandom));
      frame_q.push_back(len_field[7:0]);
      frame_q.push_back(len_field[15:8]);
      repeat (payload + 2) frame_q.push_back(sfr_pkg::BYTE_W'($urandom));
   endfunction

   function automatic void trim_frame(int unsigned n);
      while (frame_q.size() > n) void'(frame_q.pop_back());
   endfunction

   task automatic send_frame(int tick_pct);
      for (int i = 0; i < frame_q.size(); i++) begin
         if ($urandom_range(0, 99) < tick_pct)
            send_req(sfr_pkg::OP_TICK, sfr_pkg::BYTE_W'($urandom));
         send_req(sfr_pkg::OP_BYTE, frame_q[i]);
      end
   endtask

   task automatic abandon_frame();
      int n;
      n = (sb.cfg.rx_timeout == 0) ? 1 : sb.cfg.rx_timeout;
      repeat (n) send_req(sfr_pkg::OP_TICK, sfr_pkg::BYTE_W'($urandom));
   endtask

   task automatic send_random_frame(int tick_pct);
      frame_kind_type kind;
      int unsigned    limit;
      int unsigned    len;
      int             pick;
      limit = sb.cfg.max_payload;
      if (limit > sfr_pkg::FRAME_BYTES_DEF - sfr_pkg::FIXED_BYTES)
         limit = sfr_pkg::FRAME_BYTES_DEF - sfr_pkg::FIXED_BYTES;
      pick = $urandom_range(0, 15);
      kind = (pick < 10) ? FR_GOOD : frame_kind_type'(pick - 9);
      case (kind)
         FR_GOOD: begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, limit)
                                              : $urandom_range(0, (limit < 6) ? limit : 6);
            build_frame(len, len);
            send_frame(tick_pct);
         end
         FR_BAD_SYNC: begin
            build_frame(0, 0);
            if ($urandom_range(0, 1) == 0) begin
               frame_q[0] = frame_q[0] ^ sfr_pkg::BYTE_W'($urandom_range(1, 255));
            end else begin
               frame_q[1] = frame_q[1] ^ sfr_pkg::BYTE_W'($urandom_range(1, 255));
            end
            trim_frame(sfr_pkg::CNT_SYNC_HI);
            send_frame(tick_pct);
         end
         FR_BAD_VER: begin
            build_frame(0, 0);
            frame_q[2] = frame_q[2] ^ sfr_pkg::BYTE_W'($urandom_range(1, 255));
            trim_frame(sfr_pkg::CNT_VERSION);
            send_frame(tick_pct);
         end
         FR_BAD_LEN: begin
            len = ($urandom_range(0, 1) == 0) ? $urandom_range(limit + 1, limit + 4)
                                              : $urandom_range(limit + 1, 16'hFFFF);
            build_frame(len, 0);
            trim_frame(sfr_pkg::CNT_LEN_HI);
            send_frame(tick_pct);
         end
         FR_CUT: begin
            len = $urandom_range(0, (limit < 6) ? limit : 6);
            build_frame(len, len);
            trim_frame($urandom_range(1, frame_q.size() - 1));
            send_frame(tick_pct);
            if (sb.cfg.rx_timeout <= 64) abandon_frame();
         end
         FR_NOISE: begin
            repeat ($urandom_range(1, 4))
               send_req(sfr_pkg::OP_BYTE, sfr_pkg::BYTE_W'($urandom));
         end
         default: begin
            repeat ($urandom_range(1, 5))
               send_req(sfr_pkg::OP_TICK, sfr_pkg::BYTE_W'($urandom));
         end
      endcase
   endtask

   task automatic random_phase(int n, int tick_pct);
      int target;
      target = items_sent + n;
      while (items_sent < target) send_random_frame(tick_pct);
   endtask

   function automatic logic [sfr_pkg::CSR_DATA_W-1:0] random_timeout();
      return ($urandom_range(0, 1) == 0) ? sfr_pkg::CSR_DATA_W'($urandom_range(1, 40))
                                         : sfr_pkg::CSR_DATA_W'($urandom_range(41, 1023));
   endfunction

   initial begin
      #40_000_000;
      $display("sync_length_frame_receiver_tb failed");
      $finish;
   end

   initial begin
      sb = new();
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.operation <= sfr_pkg::OP_BYTE;
      req_bus.rx_byte <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: idle tick, each header failure and a frame with an empty payload.
      send_req(sfr_pkg::OP_TICK, 8'hFF);
      send_req(sfr_pkg::OP_BYTE, sb.cfg.sync_word[7:0]);
      send_req(sfr_pkg::OP_BYTE, ~sb.cfg.sync_word[15:8]);
      build_frame(0, 0);
      frame_q[2] = ~frame_q[2];
      trim_frame(sfr_pkg::CNT_VERSION);
      send_frame(0);
      build_frame(0, 0);
      frame_q[3] = 8'h00;
      frame_q[4] = 8'hFF;
      send_frame(30);
      build_frame(sb.cfg.max_payload + 1, 0);
      trim_frame(sfr_pkg::CNT_LEN_HI);
      send_frame(0);

      drain(8);
      program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0001);
      random_phase(80, 2);

      drain(8);
      program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h03FF);
      build_frame(sfr_pkg::FRAME_BYTES_DEF - sfr_pkg::FIXED_BYTES,
                  sfr_pkg::FRAME_BYTES_DEF - sfr_pkg::FIXED_BYTES);
      send_frame(5);
      build_frame(sfr_pkg::FRAME_BYTES_DEF - sfr_pkg::FIXED_BYTES + 1, 0);
      trim_frame(sfr_pkg::CNT_LEN_HI);
      send_frame(0);
      build_frame(0, 0);
      trim_frame(sfr_pkg::CNT_VERSION);
      send_frame(0);
      random_phase(100, 10);

      // A timeout register of zero after masking aborts on the first tick.
      drain(8);
      program_regs(sfr_pkg::CSR_DATA_W'($urandom), sfr_pkg::CSR_DATA_W'($urandom),
                   sfr_pkg::CSR_DATA_W'($urandom), 16'h0400);
      random_phase(60, 10);

      repeat (3) begin
         drain(8);
         program_regs(sfr_pkg::CSR_DATA_W'($urandom), sfr_pkg::CSR_DATA_W'($urandom),
                      sfr_pkg::CSR_DATA_W'($urandom), random_timeout());
         random_phase(90, 10);
      end

      drain(40);
      if (sb.errors == 0) begin
         $display("sync_length_frame_receiver_tb passed");
      end else begin
         $display("sync_length_frame_receiver_tb failed");
      end
      $finish;
   end
endmodule
